### rtl/atsp_pkg.sv
// Package for the ASN.1 time string parser: lengths, ASCII codes, format and
// field codes, the days-per-month table and small digit-accumulate helpers.
// No dependencies.
`default_nettype none

package atsp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned ACC_W  = 7;
  localparam int unsigned MOD_W  = 5;

  // Format selector codes, sampled on the first byte of a string.
  localparam logic [1:0] FMT_UTC = 2'd0;
  localparam logic [1:0] FMT_GEN = 2'd1;

  // Field codes for the digit accumulators.
  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;

  localparam logic [POS_W-1:0] UTC_LEN  = 5'd13;
  localparam logic [POS_W-1:0] GEN_LEN  = 5'd15;
  localparam logic [POS_W-1:0] POS_MAX  = 5'd16;
  localparam logic [POS_W-1:0] GEN_YEAR_DIGITS = 5'd4;

  localparam logic [BYTE_W-1:0] ASCII_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_0 = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_9 = 8'h39;

  localparam logic [YEAR_W-1:0] YEAR_PIVOT = 14'd50;
  localparam logic [YEAR_W-1:0] CENTURY_20 = 14'd2000;
  localparam logic [YEAR_W-1:0] CENTURY_19 = 14'd1900;

  localparam logic [4:0]       DAYS_FEB_LEAP = 5'd29;
  localparam logic [MOD_W-1:0] MOD_25        = 5'd25;

  // Days per month, indexed by month minus one.
  function automatic logic [4:0] days_in_month(input logic [3:0] m_idx);
    logic [4:0] d;
    case (m_idx)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // (m * 10) mod 25 for a residue m below 25.
  function automatic logic [MOD_W-1:0] mul10_mod25(input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] r;
    case (m)
      5'd1, 5'd6, 5'd11, 5'd16, 5'd21: r = 5'd10;
      5'd2, 5'd7, 5'd12, 5'd17, 5'd22: r = 5'd20;
      5'd3, 5'd8, 5'd13, 5'd18, 5'd23: r = 5'd5;
      5'd4, 5'd9, 5'd14, 5'd19, 5'd24: r = 5'd15;
      default:                         r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] acc7(input logic [ACC_W-1:0] a,
                                            input logic [3:0] d);
    logic [ACC_W+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{ACC_W{1'b0}}, d};
    return t[ACC_W-1:0];
  endfunction

  function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] a,
                                              input logic [3:0] d);
    logic [YEAR_W+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {{YEAR_W{1'b0}}, d};
    return t[YEAR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/asn1_time_string_parser_core.sv
// Top level of the ASN.1 time string parser: input register, per-byte
// decode and accumulate, calendar checks and the result register.
// Depends on atsp_pkg.
`default_nettype none

// Usage
//   Slave stream: one ASCII character per item in s_axis_tdata_i, the format
//   selector in s_axis_tuser_i (0 UTCTime, 1 GeneralizedTime, other values
//   fail) and s_axis_tlast_i on the final character of each string. The
//   selector is sampled on the first character of a string.
//   Master stream: one result item per string, emitted for the character
//   marked tlast. m_axis_tuser_o is the valid flag; m_axis_tdata_o carries
//   the date and time fields, all zero when the flag is low.
//   Path: an accepted item is decoded from the input register and, for a
//   final character, its result is loaded into the result register, which
//   offers it on the master stream.
//   Throughput: one character per cycle while no final character stalls;
//   the single decode stage between the input and result registers sets it.
//   Stall: while the result register is full and not taken, characters that
//   are not final still pass through the decode stage; a final character
//   waits in the input register until the result register frees up.
//   Reset: clears both valid flags and the parser state, so the first
//   character after reset starts a new string.
module asn1_time_string_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [13:0] year, [17:14] month,
                                             // [22:18] day, [27:23] hour,
                                             // [33:28] minute, [39:34] second
  output logic             m_axis_tuser_o    // valid_res
);

  // Input register.
  logic                          in_valid_q;
  logic [atsp_pkg::BYTE_W-1:0]   in_byte_q;
  logic [1:0]                    in_type_q;
  logic                          in_last_q;

  // Parser state.
  logic [atsp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [1:0]                    fmt_q, fmt_d;
  logic                          bad_q, bad_d;
  logic [atsp_pkg::YEAR_W-1:0]   year_q, year_d;
  logic [atsp_pkg::MOD_W-1:0]    ymod_q, ymod_d;
  logic [atsp_pkg::ACC_W-1:0]    month_q, month_d;
  logic [atsp_pkg::ACC_W-1:0]    day_q, day_d;
  logic [atsp_pkg::ACC_W-1:0]    hour_q, hour_d;
  logic [atsp_pkg::ACC_W-1:0]    minute_q, minute_d;
  logic [atsp_pkg::ACC_W-1:0]    second_q, second_d;

  // Result register.
  logic                          out_valid_q, out_valid_d;
  logic [39:0]                   out_data_q, out_data_d;
  logic                          out_ok_q, out_ok_d;

  logic                          advance;
  logic                          out_load;
  logic [1:0]                    fmt;
  logic [atsp_pkg::POS_W-1:0]    len;
  logic [atsp_pkg::POS_W-1:0]    last_pos;
  logic [atsp_pkg::POS_W-1:0]    gen_off;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic                          bad_now;
  logic                          take;
  logic [2:0]                    field;
  logic [atsp_pkg::MOD_W:0]      ymod_sum;
  logic                          ok;
  logic                          in_range;
  logic [atsp_pkg::YEAR_W-1:0]   year_full;
  logic                          leap;
  logic [4:0]                    max_day;
  logic                          res_ok;

  // A final character needs the result register; other characters never do.
  assign advance  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign out_load = advance && in_last_q;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_type_q <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Per-character decode.
  always_comb begin
    fmt = (pos_q == '0) ? in_type_q : fmt_q;
    case (fmt)
      atsp_pkg::FMT_UTC: len = atsp_pkg::UTC_LEN;
      atsp_pkg::FMT_GEN: len = atsp_pkg::GEN_LEN;
      default:           len = '0;
    endcase
    last_pos = len - 5'd1;
    is_digit = (in_byte_q >= atsp_pkg::ASCII_0) && (in_byte_q <= atsp_pkg::ASCII_9);
    digit    = in_byte_q[3:0];
    bad_now  = 1'b0;
    take     = 1'b0;
    if ((len == '0) || (pos_q >= len)) begin
      bad_now = 1'b1;
    end else if (pos_q == last_pos) begin
      bad_now = (in_byte_q != atsp_pkg::ASCII_Z);
    end else if (!is_digit) begin
      bad_now = 1'b1;
    end else begin
      take = 1'b1;
    end
    // GeneralizedTime carries four year digits, then pairs as in UTCTime.
    gen_off = pos_q - atsp_pkg::GEN_YEAR_DIGITS;
    if (fmt == atsp_pkg::FMT_UTC) begin
      field = pos_q[3:1];
    end else if (pos_q < atsp_pkg::GEN_YEAR_DIGITS) begin
      field = atsp_pkg::FIELD_YEAR;
    end else begin
      field = gen_off[3:1] + 3'd1;
    end
    ymod_sum = {1'b0, atsp_pkg::mul10_mod25(ymod_q)} + {2'b0, digit};
  end

  // Next state.
  always_comb begin
    pos_d    = pos_q;
    fmt_d    = fmt_q;
    bad_d    = bad_q;
    year_d   = year_q;
    ymod_d   = ymod_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (advance) begin
      if (in_last_q) begin
        pos_d    = '0;
        fmt_d    = '0;
        bad_d    = 1'b0;
        year_d   = '0;
        ymod_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
        second_d = '0;
      end else begin
        if (pos_q < atsp_pkg::POS_MAX) begin
          pos_d = pos_q + 5'd1;
        end
        fmt_d = fmt;
        bad_d = bad_q | bad_now;
        if (take) begin
          case (field)
            atsp_pkg::FIELD_YEAR: begin
              year_d = atsp_pkg::acc14(year_q, digit);
              // The residue mod 25 tracks the leap-year century rule.
              if (ymod_sum >= {1'b0, atsp_pkg::MOD_25}) begin
                ymod_d = ymod_sum[atsp_pkg::MOD_W-1:0] - atsp_pkg::MOD_25;
              end else begin
                ymod_d = ymod_sum[atsp_pkg::MOD_W-1:0];
              end
            end
            atsp_pkg::FIELD_MONTH:  month_d  = atsp_pkg::acc7(month_q, digit);
            atsp_pkg::FIELD_DAY:    day_d    = atsp_pkg::acc7(day_q, digit);
            atsp_pkg::FIELD_HOUR:   hour_d   = atsp_pkg::acc7(hour_q, digit);
            atsp_pkg::FIELD_MINUTE: minute_d = atsp_pkg::acc7(minute_q, digit);
            default:                second_d = atsp_pkg::acc7(second_q, digit);
          endcase
        end
      end
    end
  end

  // Result checks. A passing string ends on its Z, which adds no digit, so
  // the stored accumulators are final.
  always_comb begin
    ok = !bad_q && !bad_now && (len != '0) && (pos_q == last_pos);
    if (fmt == atsp_pkg::FMT_UTC) begin
      year_full = year_q + ((year_q < atsp_pkg::YEAR_PIVOT) ? atsp_pkg::CENTURY_20
                                                           : atsp_pkg::CENTURY_19);
    end else begin
      year_full = year_q;
    end
    in_range = (month_q >= 7'd1) && (month_q <= 7'd12) && (day_q >= 7'd1) &&
               (hour_q <= 7'd23) && (minute_q <= 7'd59) && (second_q <= 7'd59);
    // Both century offsets are multiples of 25, so the residue carries over.
    leap = (year_full[1:0] == 2'b00) && ((ymod_q != '0) || (year_full[3:0] == 4'b0000));
    max_day = atsp_pkg::days_in_month(month_q[3:0] - 4'd1);
    if ((month_q == 7'd2) && leap) begin
      max_day = atsp_pkg::DAYS_FEB_LEAP;
    end
    res_ok = ok && in_range && (day_q <= {2'b00, max_day});
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_ok_d    = out_ok_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_ok_d    = res_ok;
      if (res_ok) begin
        out_data_d = {second_q[5:0], minute_q[5:0], hour_q[4:0], day_q[4:0],
                      month_q[3:0], year_full};
      end else begin
        out_data_d = '0;
      end
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fmt_q       <= '0;
      bad_q       <= 1'b0;
      year_q      <= '0;
      ymod_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fmt_q       <= fmt_d;
      bad_q       <= bad_d;
      year_q      <= year_d;
      ymod_q      <= ymod_d;
      month_q     <= month_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_ok_q   <= out_ok_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ok_q;

  // A result that waits untaken is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !out_load)
    else $error("result register overwritten while stalled");

  // The final character of a string returns the parser to its start.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((pos_q == '0) && !bad_q && (year_q == '0)))
    else $error("parser state not cleared after final character");

  // A failed result carries all-zero fields.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_data_q == '0))
    else $error("failed result with non-zero fields");

  // A passing result has month and hour in range and a non-zero day.
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |->
      ((out_data_q[17:14] >= 4'd1) && (out_data_q[17:14] <= 4'd12) &&
       (out_data_q[22:18] >= 5'd1) && (out_data_q[27:23] <= 5'd23)))
    else $error("passing result with field out of range");

endmodule

`default_nettype wire

### sim/asn1_time_string_parser_core_test.sv
// Self-checking testbench for the ASN.1 time string parser core: drives time
// strings one character per item and checks every result against a predictor.
// Depends on atsp_pkg and asn1_time_string_parser_core.

typedef logic [7:0] char_q_t[$];

// Same layout as the result tdata, year in the lowest bits.
typedef struct packed {
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
} stamp_t;

typedef struct packed {
  logic   ok;
  stamp_t stamp;
} parse_result_t;

class time_scoreboard;
  parse_result_t stamp_queue[$];
  int unsigned   mismatches;

  // Parser state as the block holds it.
  bit [4:0]  pos;
  bit [1:0]  fmt;
  bit        bad;
  bit [13:0] yr_acc;
  bit [6:0]  mo_acc;
  bit [6:0]  dy_acc;
  bit [6:0]  hr_acc;
  bit [6:0]  mi_acc;
  bit [6:0]  se_acc;

  function new();
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    pos    = '0;
    fmt    = '0;
    bad    = 1'b0;
    yr_acc = '0;
    mo_acc = '0;
    dy_acc = '0;
    hr_acc = '0;
    mi_acc = '0;
    se_acc = '0;
  endfunction

  // Advances the parser by one accepted character; on the final one it
  // queues the result that the block must produce.
  function void decode_char(logic [7:0] b, logic [1:0] sel, logic last);
    int unsigned   p;
    int unsigned   len;
    int unsigned   fld;
    int unsigned   dig;
    int unsigned   full_year;
    int unsigned   mdays;
    bit            ok;
    parse_result_t r;
    p = pos;
    if (p == 0) fmt = sel;
    if (fmt == atsp_pkg::FMT_UTC) len = atsp_pkg::UTC_LEN;
    else if (fmt == atsp_pkg::FMT_GEN) len = atsp_pkg::GEN_LEN;
    else len = 0;

    if (len == 0 || p >= len) begin
      bad = 1'b1;
    end else if (p == len - 1) begin
      if (b != atsp_pkg::ASCII_Z) bad = 1'b1;
    end else if (b < atsp_pkg::ASCII_0 || b > atsp_pkg::ASCII_9) begin
      bad = 1'b1;
    end else begin
      dig = b - atsp_pkg::ASCII_0;
      if (fmt == atsp_pkg::FMT_UTC) fld = p / 2;
      else fld = (p < 4) ? 0 : (p - 4) / 2 + 1;
      case (fld)
        atsp_pkg::FIELD_YEAR:   yr_acc = 14'(yr_acc * 10 + dig);
        atsp_pkg::FIELD_MONTH:  mo_acc = 7'(mo_acc * 10 + dig);
        atsp_pkg::FIELD_DAY:    dy_acc = 7'(dy_acc * 10 + dig);
        atsp_pkg::FIELD_HOUR:   hr_acc = 7'(hr_acc * 10 + dig);
        atsp_pkg::FIELD_MINUTE: mi_acc = 7'(mi_acc * 10 + dig);
        default:                se_acc = 7'(se_acc * 10 + dig);
      endcase
    end
    if (p < atsp_pkg::POS_MAX) pos = 5'(p + 1);
    if (!last) return;

    ok = !bad && len != 0 && p == len - 1;
    full_year = yr_acc;
    if (fmt == atsp_pkg::FMT_UTC) full_year += (yr_acc < 50) ? 2000 : 1900;
    if (ok) begin
      if (mo_acc < 1 || mo_acc > 12 || dy_acc < 1 || hr_acc > 23 ||
          mi_acc > 59 || se_acc > 59) begin
        ok = 1'b0;
      end else begin
        case (mo_acc)
          2:             mdays = 28;
          4, 6, 9, 11:   mdays = 30;
          default:       mdays = 31;
        endcase
        // Gregorian rule: every fourth year, but centuries only every fourth.
        if (mo_acc == 2 && full_year % 4 == 0 &&
            (full_year % 100 != 0 || full_year % 400 == 0)) mdays = 29;
        if (dy_acc > mdays) ok = 1'b0;
      end
    end
    r = '0;
    if (ok) begin
      r.ok           = 1'b1;
      r.stamp.year   = full_year[13:0];
      r.stamp.month  = mo_acc[3:0];
      r.stamp.day    = dy_acc[4:0];
      r.stamp.hour   = hr_acc[4:0];
      r.stamp.minute = mi_acc[5:0];
      r.stamp.second = se_acc[5:0];
    end
    stamp_queue.push_back(r);
    clear();
  endfunction

  function void check_result(logic [39:0] data, logic flag);
    parse_result_t want;
    stamp_t        got;
    got = stamp_t'(data);
    if (stamp_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result item: ok=%0d data=%h", flag, data);
      return;
    end
    want = stamp_queue.pop_front();
    if (flag !== want.ok || got.year !== want.stamp.year ||
        got.month !== want.stamp.month || got.day !== want.stamp.day ||
        got.hour !== want.stamp.hour || got.minute !== want.stamp.minute ||
        got.second !== want.stamp.second) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %0d %0d-%0d-%0d %0d:%0d:%0d got %0d %0d-%0d-%0d %0d:%0d:%0d",
                 want.ok, want.stamp.year, want.stamp.month, want.stamp.day,
                 want.stamp.hour, want.stamp.minute, want.stamp.second,
                 flag, got.year, got.month, got.day, got.hour, got.minute, got.second);
    end
  endfunction
endclass

module asn1_time_string_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FMT_OTHER = 2'd2;
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam int unsigned RANDOM_CHARS = 1500;
  localparam int unsigned PHASE_CHARS  = 375;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic [1:0]  s_user = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned chars_sent = 0;

  time_scoreboard sb;

  asn1_time_string_parser_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic char_q_t to_chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // A well-formed string with random content, mostly in range.
  function automatic char_q_t random_stamp(input logic [1:0] sel);
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned hr;
    int unsigned mi;
    int unsigned se;
    string       s;
    yr = (sel == atsp_pkg::FMT_GEN) ? $urandom_range(0, 9999) : $urandom_range(0, 99);
    mo = $urandom_range(1, 12);
    dy = $urandom_range(1, 31);
    hr = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    se = $urandom_range(0, 59);
    if ($urandom_range(0, 9) == 0) begin
      // The twenty-ninth of February around leap years and centuries.
      mo = 2;
      dy = 29;
      if (sel == atsp_pkg::FMT_GEN)
        yr = $urandom_range(0, 99) * 100 + ($urandom_range(0, 1) ? 0 : 4 * $urandom_range(0, 24));
      else
        yr = 4 * $urandom_range(0, 24) + $urandom_range(0, 1);
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: mo = $urandom_range(0, 99);
        1: dy = $urandom_range(0, 99);
        2: hr = $urandom_range(0, 99);
        3: mi = $urandom_range(0, 99);
        default: se = $urandom_range(0, 99);
      endcase
    end
    if (sel == atsp_pkg::FMT_GEN)
      s = $sformatf("%04d%02d%02d%02d%02d%02dZ", yr, mo, dy, hr, mi, se);
    else
      s = $sformatf("%02d%02d%02d%02d%02d%02dZ", yr, mo, dy, hr, mi, se);
    return to_chars(s);
  endfunction

  task automatic send_char(input logic [7:0] b, input logic [1:0] sel, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= sel;
    s_last  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.decode_char(b, sel, last);
    chars_sent++;
  endtask

  // The first character carries first_sel, the others rest_sel.
  task automatic send_chars(input char_q_t chars, input logic [1:0] first_sel,
                            input logic [1:0] rest_sel);
    for (int i = 0; i < chars.size(); i++)
      send_char(chars[i], (i == 0) ? first_sel : rest_sel, i == chars.size() - 1);
  endtask

  task automatic send_text(input string s, input logic [1:0] sel);
    send_chars(to_chars(s), sel, sel);
  endtask

  initial begin
    char_q_t     chars;
    logic [1:0]  sel;
    logic [1:0]  rest;
    int unsigned kind;
    int unsigned start;
    int unsigned phase;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("491231235959Z", atsp_pkg::FMT_UTC);
    send_text("500101000000Z", atsp_pkg::FMT_UTC);
    send_text("99991231235959Z", atsp_pkg::FMT_GEN);
    send_text("00000101000000Z", atsp_pkg::FMT_GEN);
    send_text("20000229120000Z", atsp_pkg::FMT_GEN);
    send_text("19000229120000Z", atsp_pkg::FMT_GEN);
    send_text("240229000000Z", atsp_pkg::FMT_UTC);
    send_text("230229000000Z", atsp_pkg::FMT_UTC);
    send_text("240001000000Z", atsp_pkg::FMT_UTC);
    send_text("241301000000Z", atsp_pkg::FMT_UTC);
    send_text("240100000000Z", atsp_pkg::FMT_UTC);
    send_text("240431000000Z", atsp_pkg::FMT_UTC);
    send_text("240101240000Z", atsp_pkg::FMT_UTC);
    send_text("240101006000Z", atsp_pkg::FMT_UTC);
    send_text("240101000060Z", atsp_pkg::FMT_UTC);
    send_text("24010100a000Z", atsp_pkg::FMT_UTC);
    send_text("240101000000X", atsp_pkg::FMT_UTC);
    send_text("2401", atsp_pkg::FMT_UTC);
    send_text("2024010100000012345", atsp_pkg::FMT_GEN);
    send_text("240101000000Z", FMT_OTHER);
    send_text("240101000000Z", FMT_SPARE);
    // The selector is only taken from the first character of a string.
    send_chars(to_chars("240101000000Z"), atsp_pkg::FMT_UTC, atsp_pkg::FMT_GEN);
    chars.delete();
    chars.push_back(8'hFF);
    chars.push_back(8'h00);
    send_chars(chars, atsp_pkg::FMT_GEN, FMT_SPARE);

    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      phase = ((chars_sent - start) / PHASE_CHARS) % 4;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      kind  = $urandom_range(0, 99);
      sel   = 2'($urandom_range(0, 1));
      rest  = sel;
      chars = random_stamp(sel);
      if (kind >= 94) begin
        rest = 2'($urandom_range(0, 3));
      end else if (kind >= 88) begin
        sel  = 2'($urandom_range(0, 3));
        rest = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          chars.delete();
          repeat ($urandom_range(1, 20)) chars.push_back(8'($urandom_range(0, 255)));
        end
      end else if (kind >= 84) begin
        repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
      end else if (kind >= 80) begin
        chars = chars[0:$urandom_range(0, chars.size() - 2)];
      end else if (kind >= 70) begin
        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_chars(chars, sel, rest);
    end
    s_valid <= 1'b0;

    while (sb.stamp_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.stamp_queue.size() == 0) begin
      $display("asn1_time_string_parser_core_test: clean");
    end else begin
      $display("asn1_time_string_parser_core_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("asn1_time_string_parser_core_test: errors");
    $finish;
  end

endmodule

### sim.f
rtl/atsp_pkg.sv
rtl/asn1_time_string_parser_core.sv
sim/asn1_time_string_parser_core_test.sv
